// ===== src/civ_fr_pkg.sv =====
// Shared constants and types of the CI-V frame receiver.
package civ_fr_pkg;

    localparam int MAX_FRAME = 16;
    localparam int LEN_W     = $clog2(MAX_FRAME + 2);

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int FREQ_W   = 34;
    localparam int NIB_W    = 4;
    localparam int DIGITS   = 10;
    localparam int BCD_W    = DIGITS * NIB_W;
    localparam int CNT_W    = $clog2(DIGITS + 1);

    // frame bytes 0..9 are the only fixed positions the checks read
    localparam int KEEP_BYTES = 10;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BYTE_W-1:0] PREAMBLE       = 8'hFE;
    localparam logic [BYTE_W-1:0] END_BYTE       = 8'hFD;
    localparam logic [BYTE_W-1:0] CMD_FREQ_XFER  = 8'h00;
    localparam logic [BYTE_W-1:0] CMD_MODE_XFER  = 8'h01;
    localparam logic [BYTE_W-1:0] CMD_FREQ_GET   = 8'h03;
    localparam logic [BYTE_W-1:0] CMD_MODE_GET   = 8'h04;
    localparam logic [BYTE_W-1:0] RIG_ADDR_RESET = 8'd88;

    localparam logic [LEN_W-1:0] ECHO_MIN_LEN = LEN_W'(3);
    localparam logic [LEN_W-1:0] MIN_LEN      = LEN_W'(6);
    localparam logic [LEN_W-1:0] MODE_MIN_LEN = LEN_W'(7);
    localparam logic [LEN_W-1:0] FREQ_MIN_LEN = LEN_W'(11);
    localparam logic [LEN_W-1:0] MAX_LEN      = LEN_W'(MAX_FRAME);

    localparam logic [STATUS_W-1:0] ST_COLLECT  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FREQ     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MODE     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ECHO     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ERROR    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd6;

    // one classified byte: status, BCD digits most significant first, mode byte
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BCD_W-1:0]    bcd;
        logic [BYTE_W-1:0]   mode;
    } t_q_entry;

endpackage

// ===== src/civ_fr_if.sv =====
// Valid/ready channel interfaces of the CI-V frame receiver.
interface civ_fr_in_if;
    import civ_fr_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface civ_fr_out_if;
    import civ_fr_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [FREQ_W-1:0]   frequency;
    logic                freq_valid;
    logic [BYTE_W-1:0]   mode;
    logic                mode_valid;

    modport source (output valid, output status, output frequency, output freq_valid,
                    output mode, output mode_valid, input ready);
    modport sink   (input valid, input status, input frequency, input freq_valid,
                    input mode, input mode_valid, output ready);
endinterface

// ===== src/civ_fr_front.sv =====
// Front end: byte intake, frame assembly and frame classification.
module civ_fr_front import civ_fr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [BYTE_W-1:0] i_cfg_wr_data,
    civ_fr_in_if.sink         i_rx,
    input  logic              i_q_full,
    output logic              o_push,
    output t_q_entry          o_push_data
);

    logic [BYTE_W-1:0] r_rig_addr;
    logic [1:0]        r_pre_cnt;
    logic [1:0]        n_pre_cnt;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  n_len;
    logic [LEN_W-1:0]  len_inc;
    logic [BYTE_W-1:0] r_frame_byte [KEEP_BYTES];
    logic [BYTE_W-1:0] fb [KEEP_BYTES];
    logic [BYTE_W-1:0] r_last;
    logic [BYTE_W-1:0] cur_last;
    logic [BYTE_W-1:0] ch;
    logic              accept;
    logic              is_pre;
    logic              is_end;
    logic              do_store;
    logic              overflow;
    logic              bad_frame;
    logic [STATUS_W-1:0] status;

    assign ch         = i_rx.rx_byte;
    assign i_rx.ready = !i_q_full;
    assign accept     = i_rx.valid && !i_q_full;

    assign is_pre   = (ch == PREAMBLE);
    assign is_end   = (ch == END_BYTE);
    assign do_store = is_pre || (r_pre_cnt == 2'd2);
    assign len_inc  = r_len + LEN_W'(do_store);
    assign overflow = (len_inc > MAX_LEN);
    assign n_len    = (overflow || is_end) ? '0 : len_inc;
    assign cur_last = do_store ? ch : r_last;

    always_comb begin
        n_pre_cnt = r_pre_cnt;
        if (is_pre && r_pre_cnt != 2'd3) begin
            n_pre_cnt = r_pre_cnt + 2'd1;
        end
        if (is_end || overflow) begin
            n_pre_cnt = 2'd0;
        end
    end

    // frame bytes as they stand after this byte
    always_comb begin
        for (int i = 0; i < KEEP_BYTES; i++) begin
            fb[i] = (do_store && r_len == LEN_W'(i)) ? ch : r_frame_byte[i];
        end
    end

    assign bad_frame = (fb[0] != PREAMBLE) || (fb[1] != PREAMBLE) ||
                       (cur_last != END_BYTE) || (fb[3] != r_rig_addr);

    always_comb begin
        status = ST_COLLECT;
        if (overflow) begin
            status = ST_OVERFLOW;
        end else if (is_end) begin
            if (len_inc >= ECHO_MIN_LEN && fb[2] == r_rig_addr) begin
                status = ST_ECHO;
            end else if (len_inc < MIN_LEN || bad_frame) begin
                status = ST_ERROR;
            end else if (fb[4] == CMD_FREQ_XFER || fb[4] == CMD_FREQ_GET) begin
                status = (len_inc < FREQ_MIN_LEN) ? ST_ERROR : ST_FREQ;
            end else if (fb[4] == CMD_MODE_XFER || fb[4] == CMD_MODE_GET) begin
                status = (len_inc < MODE_MIN_LEN) ? ST_ERROR : ST_MODE;
            end else begin
                status = ST_IGNORED;
            end
        end
    end

    assign o_push             = accept;
    assign o_push_data.status = status;
    assign o_push_data.bcd    = {fb[9], fb[8], fb[7], fb[6], fb[5]};
    assign o_push_data.mode   = fb[5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rig_addr <= RIG_ADDR_RESET;
            r_pre_cnt  <= 2'd0;
            r_len      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_rig_addr <= i_cfg_wr_data;
            end
            if (accept) begin
                r_pre_cnt <= n_pre_cnt;
                r_len     <= n_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && do_store) begin
            r_last <= ch;
        end
        for (int i = 0; i < KEEP_BYTES; i++) begin
            if (accept && do_store && r_len == LEN_W'(i)) begin
                r_frame_byte[i] <= ch;
            end
        end
    end

endmodule

// ===== src/civ_fr_queue.sv =====
// Short FIFO of classified bytes between front and back end.
module civ_fr_queue import civ_fr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_q_entry i_push_data,
    output logic     o_full,
    input  logic     i_pop,
    output logic     o_empty,
    output t_q_entry o_pop_data
);

    t_q_entry          r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full     = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_entry[r_rd_ptr];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ===== src/civ_fr_back.sv =====
// Back end: BCD to binary conversion, report state and result register.
module civ_fr_back import civ_fr_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  t_q_entry      i_q_data,
    output logic          o_pop,
    civ_fr_out_if.source  o_res
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_CONV = 1'b1;

    logic                r_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [FREQ_W-1:0]   r_acc;
    logic [FREQ_W-1:0]   acc_next;
    logic [BCD_W-1:0]    r_bcd;
    logic [FREQ_W-1:0]   r_freq_value;
    logic                r_freq_seen;
    logic [BYTE_W-1:0]   r_mode_value;
    logic                r_mode_seen;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [FREQ_W-1:0]   r_out_freq;
    logic                r_out_freq_valid;
    logic [BYTE_W-1:0]   r_out_mode;
    logic                r_out_mode_valid;
    logic                slot_free;
    logic                is_freq;
    logic                is_mode;
    logic                emit_direct;
    logic                emit_freq;
    logic                conv_step;

    assign slot_free   = !r_out_valid || o_res.ready;
    assign is_freq     = (i_q_data.status == ST_FREQ);
    assign is_mode     = (i_q_data.status == ST_MODE);
    assign o_pop       = (r_state == S_IDLE) && !i_q_empty && slot_free;
    assign emit_direct = o_pop && !is_freq;
    assign conv_step   = (r_state == S_CONV) && (r_cnt != '0);
    assign emit_freq   = (r_state == S_CONV) && (r_cnt == '0) && slot_free;

    // acc * 10 + next digit
    assign acc_next = {r_acc[FREQ_W-4:0], 3'b000} + {r_acc[FREQ_W-2:0], 1'b0} +
                      FREQ_W'(r_bcd[BCD_W-1 -: NIB_W]);

    assign o_res.valid      = r_out_valid;
    assign o_res.status     = r_out_status;
    assign o_res.frequency  = r_out_freq;
    assign o_res.freq_valid = r_out_freq_valid;
    assign o_res.mode       = r_out_mode;
    assign o_res.mode_valid = r_out_mode_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
            r_freq_value <= '0;
            r_freq_seen  <= 1'b0;
            r_mode_value <= '0;
            r_mode_seen  <= 1'b0;
        end else begin
            if (emit_direct || emit_freq) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop && is_freq) begin
                        r_state <= S_CONV;
                        r_cnt   <= CNT_W'(DIGITS);
                    end else if (o_pop && is_mode) begin
                        r_mode_value <= i_q_data.mode;
                        r_mode_seen  <= 1'b1;
                    end
                end
                S_CONV: begin
                    if (conv_step) begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end else if (slot_free) begin
                        r_state      <= S_IDLE;
                        r_freq_value <= r_acc;
                        r_freq_seen  <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && is_freq) begin
            r_acc <= '0;
            r_bcd <= i_q_data.bcd;
        end else if (conv_step) begin
            r_acc <= acc_next;
            r_bcd <= {r_bcd[BCD_W-NIB_W-1:0], {NIB_W{1'b0}}};
        end
        if (emit_direct) begin
            r_out_status     <= i_q_data.status;
            r_out_freq       <= r_freq_value;
            r_out_freq_valid <= r_freq_seen;
            r_out_mode       <= is_mode ? i_q_data.mode : r_mode_value;
            r_out_mode_valid <= is_mode || r_mode_seen;
        end else if (emit_freq) begin
            r_out_status     <= ST_FREQ;
            r_out_freq       <= r_acc;
            r_out_freq_valid <= 1'b1;
            r_out_mode       <= r_mode_value;
            r_out_mode_valid <= r_mode_seen;
        end
    end

endmodule

// ===== src/civ_frame_receiver.sv =====
// Top level of the CI-V frame receiver.
//
// Input channel i_rx carries one received link byte per transfer; output
// channel o_res returns exactly one result per input byte, in order: a status
// code plus the current frequency, mode and their valid flags.
// The rig address register is written through i_cfg_wr_en/i_cfg_wr_data and
// resets to 88; write it only while no byte is in flight.
// Each byte's classification is written into the queue, and the back end moves
// it into the result register when it pops the entry. For the end byte of a
// frequency report the back end converts the ten BCD digits one per cycle
// with a shared multiply-by-ten adder before loading the result register.
// Throughput: one byte per cycle except behind a frequency report, where
// the converter holds the back end; a two-entry queue lets the front end
// keep taking bytes meanwhile.
// When o_res stalls, the result register holds; once the queue fills,
// i_rx.ready drops.
// Synchronous reset clears the frame assembly, queue, reported frequency and
// mode, and the valid flag of the result register.
module civ_frame_receiver import civ_fr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [BYTE_W-1:0] i_cfg_wr_data,
    civ_fr_in_if.sink         i_rx,
    civ_fr_out_if.source      o_res
);

    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_empty;
    t_q_entry q_push_data;
    t_q_entry q_pop_data;

    civ_fr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_rx          (i_rx),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_push_data   (q_push_data)
    );

    civ_fr_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_empty     (q_empty),
        .o_pop_data  (q_pop_data)
    );

    civ_fr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_pop_data),
        .o_pop     (q_pop),
        .o_res     (o_res)
    );

endmodule

// ===== src/civ_fr_checker.sv =====
// Port-level assertions of the CI-V frame receiver, bound to the top level.
module civ_fr_checker import civ_fr_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [STATUS_W-1:0] i_out_status,
    input logic                i_out_freq_valid
);

    logic       in_xfer;
    logic       out_xfer;
    logic [3:0] r_pending;
    logic       r_freq_seen;

    assign in_xfer  = i_in_valid && i_in_ready;
    assign out_xfer = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= '0;
            r_freq_seen <= 1'b0;
        end else begin
            r_pending <= r_pending + 4'(in_xfer) - 4'(out_xfer);
            if (out_xfer && i_out_freq_valid) begin
                r_freq_seen <= 1'b1;
            end
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_no_extra_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pending != 4'd0)
        else $error("result without an outstanding byte");

    a_freq_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_freq_seen |-> i_out_freq_valid)
        else $error("freq_valid cleared after a frequency report");

    a_freq_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status == ST_FREQ |-> i_out_freq_valid)
        else $error("frequency update without freq_valid");

endmodule

bind civ_frame_receiver civ_fr_checker u_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_rx.valid),
    .i_in_ready       (i_rx.ready),
    .i_out_valid      (o_res.valid),
    .i_out_ready      (o_res.ready),
    .i_out_status     (o_res.status),
    .i_out_freq_valid (o_res.freq_valid)
);
